@@ rtl/multichannel_accumulator_pwm_core_defines.svh @@
// Assertion macros used by the multichannel accumulator PWM engine.
`ifndef MULTICHANNEL_ACCUMULATOR_PWM_CORE_DEFINES_SVH
`define MULTICHANNEL_ACCUMULATOR_PWM_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define MAPWM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MAPWM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define MAPWM_ASSERT_SAME(lbl, ante, cons, msg)
`define MAPWM_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

@@ rtl/mapwm_pkg.sv @@
// Types and constants shared by the multichannel accumulator PWM modules.
`timescale 1ns / 1ps

package mapwm_pkg;

  localparam int ACTIVE_W   = 5;
  localparam int PERIOD_W   = 16;
  localparam int CHANNEL_W  = 4;
  localparam int DUTY_W     = 16;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic OP_TICK     = 1'b0;
  localparam logic OP_SET_DUTY = 1'b1;

  localparam logic [CFG_INDEX_W-1:0] CFG_ACTIVE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PERIOD = 2'd1;

  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 5'd16;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd256;

  typedef struct packed {
    logic                 operation;
    logic [CHANNEL_W-1:0] channel;
    logic [DUTY_W-1:0]    duty;
  } item_t;

  typedef struct packed {
    logic [CHANNEL_W-1:0] out_channel;
    logic                 pulse;
    logic                 last;
  } result_t;

  typedef struct packed {
    logic [ACTIVE_W-1:0] active_channels;
    logic [PERIOD_W-1:0] period_steps;
  } cfg_t;

endpackage

@@ rtl/mapwm_ram.sv @@
// Synchronous single-write, single-read memory with per-entry written flags.
`timescale 1ns / 1ps

module mapwm_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] written;
  logic [WIDTH-1:0] rd_word;
  logic             rd_written;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // An entry that has not been written since reset reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (we) begin
      written[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rd_word    <= mem[raddr];
      rd_written <= written[raddr];
    end
  end

  assign rdata = rd_written ? rd_word : '0;

endmodule

@@ rtl/mapwm_engine.sv @@
// Channel walker: duty and accumulator memories, read-modify-write stage and result register.
`timescale 1ns / 1ps
`include "multichannel_accumulator_pwm_core_defines.svh"

module mapwm_engine #(
  parameter int MAX_CHANNELS = 16,
  parameter int COUNT_WIDTH  = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  mapwm_pkg::cfg_t    cfg,
  input  logic               item_valid,
  output logic               item_ready,
  input  mapwm_pkg::item_t   item,
  output logic               result_valid,
  input  logic               result_ready,
  output mapwm_pkg::result_t result
);

  import mapwm_pkg::*;

  localparam int AW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CNW  = $clog2(MAX_CHANNELS + 1);
  localparam int CMPW = (CNW > ACTIVE_W) ? CNW : ACTIVE_W;
  localparam int SATW = (COUNT_WIDTH > DUTY_W) ? COUNT_WIDTH : DUTY_W;
  localparam int SUMW = (COUNT_WIDTH + 1 > PERIOD_W) ? COUNT_WIDTH + 1 : PERIOD_W;
  localparam logic [COUNT_WIDTH-1:0] CNT_MASK = '1;

  logic [CMPW-1:0]        act_ext;
  logic [CNW-1:0]         n_active;
  logic [CNW-1:0]         rem;
  logic                   s1_vld;
  logic [AW-1:0]          s1_addr;
  logic [AW-1:0]          rd_addr;
  logic                   accept;
  logic                   issue;
  logic                   s1_fire;
  logic                   ch_in_range;
  logic                   set_we;
  logic [DUTY_W-1:0]      duty_lim;
  logic [SATW-1:0]        duty_sat;
  logic [COUNT_WIDTH-1:0] duty_q;
  logic [COUNT_WIDTH-1:0] acc_q;
  logic [COUNT_WIDTH-1:0] acc_new;
  logic [SUMW-1:0]        sum;
  logic [SUMW-1:0]        sum_sub;
  logic                   pulse_new;

  always_comb begin
    act_ext  = CMPW'(cfg.active_channels);
    n_active = (act_ext > CMPW'(MAX_CHANNELS)) ? CNW'(MAX_CHANNELS) : CNW'(act_ext);
  end

  // A new item is taken only once the previous tick has left the compute stage.
  assign item_ready = (rem == '0) && !s1_vld;
  assign accept     = item_valid && item_ready;

  assign ch_in_range = CMPW'(item.channel) < CMPW'(MAX_CHANNELS);
  assign set_we      = accept && (item.operation == OP_SET_DUTY) && ch_in_range;

  always_comb begin
    duty_lim = (item.duty < cfg.period_steps) ? item.duty : cfg.period_steps;
    duty_sat = (SATW'(duty_lim) > SATW'(CNT_MASK)) ? SATW'(CNT_MASK) : SATW'(duty_lim);
  end

  // The read data register holds while the compute stage is stalled, as no new read is issued.
  assign s1_fire = s1_vld && (!result_valid || result_ready);
  assign issue   = (rem != '0) && (!s1_vld || s1_fire);
  assign rd_addr = AW'(rem - 1'b1);

  always_comb begin
    sum       = SUMW'(acc_q) + SUMW'(duty_q);
    pulse_new = sum >= SUMW'(cfg.period_steps);
    sum_sub   = pulse_new ? sum - SUMW'(cfg.period_steps) : sum;
    acc_new   = (sum_sub > SUMW'(CNT_MASK)) ? CNT_MASK : COUNT_WIDTH'(sum_sub);
  end

  mapwm_ram #(
    .DEPTH (MAX_CHANNELS),
    .WIDTH (COUNT_WIDTH),
    .AW    (AW)
  ) u_duty_ram (
    .clk   (clk),
    .rst   (rst),
    .we    (set_we),
    .waddr (AW'(item.channel)),
    .wdata (COUNT_WIDTH'(duty_sat)),
    .re    (issue),
    .raddr (rd_addr),
    .rdata (duty_q)
  );

  mapwm_ram #(
    .DEPTH (MAX_CHANNELS),
    .WIDTH (COUNT_WIDTH),
    .AW    (AW)
  ) u_acc_ram (
    .clk   (clk),
    .rst   (rst),
    .we    (s1_fire),
    .waddr (s1_addr),
    .wdata (acc_new),
    .re    (issue),
    .raddr (rd_addr),
    .rdata (acc_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rem          <= '0;
      s1_vld       <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (accept && (item.operation == OP_TICK)) begin
        rem <= n_active;
      end else if (issue) begin
        rem <= rem - 1'b1;
      end
      if (issue) begin
        s1_vld <= 1'b1;
      end else if (s1_fire) begin
        s1_vld <= 1'b0;
      end
      if (s1_fire) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_addr <= rd_addr;
    end
    if (s1_fire) begin
      result.out_channel <= CHANNEL_W'(s1_addr);
      result.pulse       <= pulse_new;
      result.last        <= (s1_addr == '0);
    end
  end

  `MAPWM_ASSERT_NEXT(a_tick_starts_walk, accept && item.operation == OP_TICK && n_active != '0, rem != '0, "A tick with active channels did not start a walk.")
  `MAPWM_ASSERT_NEXT(a_stage_holds, s1_vld && !s1_fire, s1_vld && $stable(s1_addr), "A stalled compute stage lost its channel.")
  `MAPWM_ASSERT_NEXT(a_last_ends_walk, s1_fire && s1_addr == '0, rem == '0 && !s1_vld, "Work remained after channel zero was delivered.")
  `MAPWM_ASSERT_SAME(a_zero_is_final, s1_vld && s1_addr == '0, rem == '0, "Channel zero was read before the walk ended.")

endmodule

@@ rtl/multichannel_accumulator_pwm_core.sv @@
// Top level of the multichannel accumulator PWM: configuration registers and the channel walker.
//
//  Channel   Signals                                   Carries
//  item      item_valid / item_ready / item            tick or set-duty command
//  result    result_valid / result_ready / result      one pulse bit per channel
//  cfg       cfg_valid / cfg_ready / cfg_index, data   register write
//
// A set-duty item, or a tick with no active channels, is finished once transferred. A tick
// over N active channels issues one memory read per cycle unless the result register stalls,
// reading channels N - 1 down to zero from the registered duty and accumulator memories;
// the next item is taken after channel zero leaves the compute stage.
// A stalled result register holds back the read pipeline but loses nothing.
// Reset clears the per-entry written flags, so no clearing pass is needed.
`timescale 1ns / 1ps

module multichannel_accumulator_pwm_core #(
  parameter int MAX_CHANNELS = 16,
  parameter int COUNT_WIDTH  = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 item_valid,
  output logic                                 item_ready,
  input  mapwm_pkg::item_t                     item,
  output logic                                 result_valid,
  input  logic                                 result_ready,
  output mapwm_pkg::result_t                   result,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [mapwm_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [mapwm_pkg::CFG_DATA_W-1:0]     cfg_data
);

  import mapwm_pkg::*;

  cfg_t cfg;

  assign cfg_ready = 1'b1;

  // Writes to an index beyond the register list are accepted and dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.active_channels <= ACTIVE_RESET;
      cfg.period_steps    <= PERIOD_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_ACTIVE: cfg.active_channels <= ACTIVE_W'(cfg_data);
        CFG_PERIOD: cfg.period_steps    <= PERIOD_W'(cfg_data);
        default: ;
      endcase
    end
  end

  mapwm_engine #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .COUNT_WIDTH  (COUNT_WIDTH)
  ) u_engine (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule
